// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of the acquisition sequencer.
// Needs nothing else; the including file supplies the clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSMS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsms assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BSMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsms assertion failed");

`endif

// File: hdl/bsms_pkg.sv
// Shared types and constants of the bridge sensor acquisition sequencer.
// No dependencies; all other files but assert_macros.svh import this package.
`timescale 1ns / 1ps

package bsms_pkg;

   // Bus operation codes carried in bus_op.
   localparam logic [1:0] BUS_NONE  = 2'd0;
   localparam logic [1:0] BUS_WRITE = 2'd1;
   localparam logic [1:0] BUS_READ1 = 2'd2;
   localparam logic [1:0] BUS_READ4 = 2'd3;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_BRIDGE_COMMAND  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BRIDGE_ARG_HIGH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BRIDGE_ARG_LOW  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TEMP_COMMAND    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CONVERSION_WAIT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_CYCLE_PAUSE     = 3'd5;

   localparam int unsigned CSR_DATA_W = 16;

   // Timing register reset values, status busy mask and temperature argument byte.
   localparam logic [15:0] CONVERSION_WAIT_RESET = 16'd10;
   localparam logic [15:0] CYCLE_PAUSE_RESET     = 16'd200;
   localparam logic [7:0]  STATUS_BUSY_MASK      = 8'h20;
   localparam logic [7:0]  TEMP_ARG_BYTE         = 8'h00;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        bus_ok;
      logic [7:0]  rx_status;
      logic [7:0]  rx_byte1;
      logic [7:0]  rx_byte2;
      logic [7:0]  rx_byte3;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  bus_op;
      logic [7:0]  tx_byte0;
      logic [7:0]  tx_byte1;
      logic [7:0]  tx_byte2;
      logic [23:0] bridge_value;
      logic [15:0] temp_value;
      logic        bridge_new;
      logic        temp_new;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  wdata;
   } csr_payload_type;

   // Current configuration as seen by the sequencing core.
   typedef struct packed {
      logic [7:0]  bridge_command;
      logic [7:0]  bridge_arg_high;
      logic [7:0]  bridge_arg_low;
      logic [7:0]  temp_command;
      logic [15:0] conversion_wait;
      logic [15:0] cycle_pause;
   } cfg_type;

endpackage

// File: hdl/bsms_channels.sv
// Valid/ready channel interfaces for poll items, result items and register writes.
// Depends on bsms_pkg for the payload types.
`timescale 1ns / 1ps

interface bsms_req_if import bsms_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface bsms_rsp_if import bsms_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface bsms_csr_if import bsms_pkg::*; ();
   logic            valid;
   logic            ready;
   csr_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/bridge_sensor_measure_sequencer.sv
// Top level of the bridge/temperature acquisition sequencer.
// Depends on bsms_pkg, bsms_channels, bsms_csr and bsms_core.
`timescale 1ns / 1ps

// How the block is used.
// Each item on req_chan is one poll: the current time in milliseconds and the
// bytes that the bus returned for the read that this poll's own result names.
// Each poll produces exactly one item on rsp_chan, naming the bus operation
// (none, three-byte write, one-byte status read or four-byte data read), the
// bytes to write, the latest bridge and temperature readings and flags that mark
// a freshly captured reading.
// csr_chan writes the six configuration registers; it is always ready and should
// be used only while no poll is in flight.
// A poll is taken into an input register on the edge it is accepted, is decided
// by the phase logic while it waits there and lands in the output register once
// that register is empty or being read, which raises rsp_chan.valid.
// Unless the receiver stalls, one poll can be accepted in every cycle; the
// throughput of one item per cycle is set by the single decision stage between
// the input and output registers. When the receiver stalls, the result waits in
// the output register and one more poll is still taken into the input register;
// req_chan.ready then drops until the output register drains.
// Synchronous reset empties both registers, returns the sequence to the bridge
// conversion write, clears the time mark and stored readings, and restores the
// register defaults (waits of 10 ms and 200 ms, command bytes zero).
module bridge_sensor_measure_sequencer import bsms_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   bsms_req_if.sink   req_chan,
   bsms_rsp_if.source rsp_chan,
   bsms_csr_if.sink   csr_chan
);

   cfg_type         cfg;
   req_payload_type in_data_ff;
   logic            in_valid_ff;
   logic            in_valid_in;
   rsp_payload_type out_data_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type result;
   logic            advance;
   logic            step;
   logic            req_fire;

   // Register writes are never held off.
   assign csr_chan.ready = 1'b1;

   bsms_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_chan.valid),
      .wr_index (csr_chan.data.index),
      .wr_data  (csr_chan.data.wdata),
      .cfg      (cfg)
   );

   // The output register can take a new result when it is empty or being read.
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   bsms_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cfg    (cfg),
      .poll   (in_data_ff),
      .result (result)
   );

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = step || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load only on a transfer and need no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_chan.data;
      end
      if (step) begin
         out_data_ff <= result;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_data_ff;

endmodule

// File: hdl/bsms_csr.sv
// Configuration register file of the acquisition sequencer.
// Depends on bsms_pkg; writes to indexes beyond the list are dropped.
`timescale 1ns / 1ps

module bsms_csr import bsms_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [CSR_INDEX_W-1:0] wr_index,
   input  logic [CSR_DATA_W-1:0]  wr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            REG_BRIDGE_COMMAND:  cfg_in.bridge_command  = wr_data[7:0];
            REG_BRIDGE_ARG_HIGH: cfg_in.bridge_arg_high = wr_data[7:0];
            REG_BRIDGE_ARG_LOW:  cfg_in.bridge_arg_low  = wr_data[7:0];
            REG_TEMP_COMMAND:    cfg_in.temp_command    = wr_data[7:0];
            REG_CONVERSION_WAIT: cfg_in.conversion_wait = wr_data;
            REG_CYCLE_PAUSE:     cfg_in.cycle_pause     = wr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bridge_command  <= 8'd0;
         cfg_ff.bridge_arg_high <= 8'd0;
         cfg_ff.bridge_arg_low  <= 8'd0;
         cfg_ff.temp_command    <= 8'd0;
         cfg_ff.conversion_wait <= CONVERSION_WAIT_RESET;
         cfg_ff.cycle_pause     <= CYCLE_PAUSE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/bsms_core.sv
// Phase sequencer of the acquisition cycle: phase, time mark and stored readings,
// with the combinational decision for one poll. Depends on bsms_pkg.
`timescale 1ns / 1ps

module bsms_core import bsms_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  cfg_type         cfg,
   input  req_payload_type poll,
   output rsp_payload_type result
);

   typedef enum logic [3:0] {
      PH_BRIDGE_WRITE = 4'd0,
      PH_BRIDGE_WAIT  = 4'd1,
      PH_BRIDGE_POLL  = 4'd2,
      PH_BRIDGE_READ  = 4'd3,
      PH_TEMP_WRITE   = 4'd4,
      PH_TEMP_WAIT    = 4'd5,
      PH_TEMP_POLL    = 4'd6,
      PH_TEMP_READ    = 4'd7,
      PH_PAUSE        = 4'd8
   } phase_type;

   phase_type   phase_ff,     phase_in;
   logic [31:0] time_mark_ff, time_mark_in;
   logic [23:0] bridge_ff,    bridge_in;
   logic [15:0] temp_ff,      temp_in;

   logic [31:0] elapsed;
   logic        wait_done;
   logic        pause_done;
   logic        sensor_ready;

   assign elapsed      = poll.now_ms - time_mark_ff;
   assign wait_done    = elapsed > {16'd0, cfg.conversion_wait};
   assign pause_done   = elapsed > {16'd0, cfg.cycle_pause};
   assign sensor_ready = poll.bus_ok && ((poll.rx_status & STATUS_BUSY_MASK) == 8'h00);

   always_comb begin
      phase_in     = phase_ff;
      time_mark_in = time_mark_ff;
      bridge_in    = bridge_ff;
      temp_in      = temp_ff;
      result       = '0;
      unique case (phase_ff)
         PH_BRIDGE_WRITE: begin
            result.bus_op   = BUS_WRITE;
            result.tx_byte0 = cfg.bridge_command;
            result.tx_byte1 = cfg.bridge_arg_high;
            result.tx_byte2 = cfg.bridge_arg_low;
            time_mark_in    = poll.now_ms;
            phase_in        = PH_BRIDGE_WAIT;
         end
         PH_BRIDGE_WAIT: begin
            if (wait_done) begin
               phase_in     = PH_BRIDGE_POLL;
               time_mark_in = poll.now_ms;
            end
         end
         PH_BRIDGE_POLL: begin
            result.bus_op = BUS_READ1;
            if (sensor_ready) begin
               phase_in = PH_BRIDGE_READ;
            end
         end
         PH_BRIDGE_READ: begin
            result.bus_op = BUS_READ4;
            if (poll.bus_ok) begin
               bridge_in         = {poll.rx_byte1, poll.rx_byte2, poll.rx_byte3};
               result.bridge_new = 1'b1;
            end
            phase_in = PH_TEMP_WRITE;
         end
         PH_TEMP_WRITE: begin
            result.bus_op   = BUS_WRITE;
            result.tx_byte0 = cfg.temp_command;
            result.tx_byte1 = TEMP_ARG_BYTE;
            result.tx_byte2 = TEMP_ARG_BYTE;
            time_mark_in    = poll.now_ms;
            phase_in        = PH_TEMP_WAIT;
         end
         PH_TEMP_WAIT: begin
            if (wait_done) begin
               phase_in     = PH_TEMP_POLL;
               time_mark_in = poll.now_ms;
            end
         end
         PH_TEMP_POLL: begin
            result.bus_op = BUS_READ1;
            if (sensor_ready) begin
               phase_in = PH_TEMP_READ;
            end
         end
         PH_TEMP_READ: begin
            result.bus_op = BUS_READ4;
            if (poll.bus_ok) begin
               temp_in         = {poll.rx_byte1, poll.rx_byte2};
               result.temp_new = 1'b1;
            end
            time_mark_in = poll.now_ms;
            phase_in     = PH_PAUSE;
         end
         PH_PAUSE: begin
            if (pause_done) begin
               phase_in     = PH_BRIDGE_WRITE;
               time_mark_in = poll.now_ms;
            end
         end
         default: begin
            phase_in = PH_BRIDGE_WRITE;
         end
      endcase
      result.bridge_value = bridge_in;
      result.temp_value   = temp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_BRIDGE_WRITE;
         time_mark_ff <= 32'd0;
         bridge_ff    <= 24'd0;
         temp_ff      <= 16'd0;
      end else if (step) begin
         phase_ff     <= phase_in;
         time_mark_ff <= time_mark_in;
         bridge_ff    <= bridge_in;
         temp_ff      <= temp_in;
      end
   end

endmodule

// File: hdl/bsms_checker.sv
// Port-level checker for the acquisition sequencer, bound to the top level.
// Depends on bsms_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsms_checker import bsms_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   logic rsp_stall;
   logic tx_idle;
   logic tx_zero;
   logic any_new;
   logic new_ok;
   logic read_taken;
   logic after_read;

   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign tx_idle    = rsp_valid && (rsp_data.bus_op != BUS_WRITE);
   assign tx_zero    = (rsp_data.tx_byte0 == 8'h00) && (rsp_data.tx_byte1 == 8'h00) &&
                       (rsp_data.tx_byte2 == 8'h00);
   assign any_new    = rsp_valid && (rsp_data.bridge_new || rsp_data.temp_new);
   assign new_ok     = (rsp_data.bus_op == BUS_READ4) &&
                       !(rsp_data.bridge_new && rsp_data.temp_new);
   assign read_taken = rsp_valid && rsp_ready && (rsp_data.bus_op == BUS_READ4);
   assign after_read = !rsp_valid || (rsp_data.bus_op == BUS_WRITE) ||
                       (rsp_data.bus_op == BUS_NONE);

   // A result held back by the receiver keeps its contents.
   `BSMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))

   // Write bytes are zero unless the result requests a write.
   `BSMS_ASSERT_SAME(a_tx_zero, clock, reset, tx_idle, tx_zero)

   // A fresh reading only comes with a data read, and never both at once.
   `BSMS_ASSERT_SAME(a_new_on_read, clock, reset, any_new, new_ok)

   // A data read is followed by a conversion write or by a step with no bus operation.
   `BSMS_ASSERT_NEXT(a_read_after_write, clock, reset, read_taken, after_read)

endmodule

bind bridge_sensor_measure_sequencer bsms_checker u_bsms_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

// File: tb/testbench.sv
// Self-checking testbench for the bridge sensor acquisition sequencer.
// Depends on bsms_pkg, the bsms_channels interfaces and the sequencer RTL.
`timescale 1ns / 1ps

module testbench;
   import bsms_pkg::*;

   // Cycle budget for the whole run, with room for the slowest legal run, with
   // both sides idling heavily and one long hold-off.
   localparam int unsigned CYCLE_LIMIT  = 200000;
   // Length of the deliberate receiver hold-off that backs the block up.
   localparam int unsigned HOLD_CYCLES  = 400;
   // Margin after the last result has come out, before the block is touched again.
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned SEGMENTS     = 8;
   localparam int unsigned SEG_POLLS    = 230;

   // Phases of the acquisition cycle, in the order the sequencer walks them.
   typedef enum logic [3:0] {
      PH_BRIDGE_WRITE,
      PH_BRIDGE_WAIT,
      PH_BRIDGE_STATUS,
      PH_BRIDGE_READ,
      PH_TEMP_WRITE,
      PH_TEMP_WAIT,
      PH_TEMP_STATUS,
      PH_TEMP_READ,
      PH_PAUSE
   } seq_phase_type;

   // The scoreboard carries its own copy of the sequencer state and registers.
   // Every accepted poll advances that copy and leaves one expected result item;
   // every result item leaving the block is compared with the oldest of them.
   class measure_scoreboard_type;
      cfg_type         cfg;
      seq_phase_type   phase;
      logic [31:0]     time_mark;
      logic [23:0]     bridge_store;
      logic [15:0]     temp_store;
      rsp_payload_type expected_q[$];
      int unsigned     mismatches;
      int unsigned     results;
      int unsigned     bridge_captures;
      int unsigned     temp_captures;

      function new();
         cfg = '{bridge_command: 8'h00, bridge_arg_high: 8'h00, bridge_arg_low: 8'h00,
                 temp_command: 8'h00, conversion_wait: CONVERSION_WAIT_RESET,
                 cycle_pause: CYCLE_PAUSE_RESET};
         phase        = PH_BRIDGE_WRITE;
         time_mark    = '0;
         bridge_store = '0;
         temp_store   = '0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] wdata);
         case (index)
            REG_BRIDGE_COMMAND:  cfg.bridge_command  = wdata[7:0];
            REG_BRIDGE_ARG_HIGH: cfg.bridge_arg_high = wdata[7:0];
            REG_BRIDGE_ARG_LOW:  cfg.bridge_arg_low  = wdata[7:0];
            REG_TEMP_COMMAND:    cfg.temp_command    = wdata[7:0];
            REG_CONVERSION_WAIT: cfg.conversion_wait = wdata;
            REG_CYCLE_PAUSE:     cfg.cycle_pause     = wdata;
            default: ;
         endcase
      endfunction

      function void note_poll(req_payload_type p);
         rsp_payload_type r;
         logic [31:0]     elapsed;
         r       = '0;
         elapsed = p.now_ms - time_mark;
         case (phase)
            PH_BRIDGE_WRITE: begin
               r.bus_op   = BUS_WRITE;
               r.tx_byte0 = cfg.bridge_command;
               r.tx_byte1 = cfg.bridge_arg_high;
               r.tx_byte2 = cfg.bridge_arg_low;
               time_mark  = p.now_ms;
               phase      = PH_BRIDGE_WAIT;
            end
            PH_BRIDGE_WAIT, PH_TEMP_WAIT: begin
               if (elapsed > {16'h0000, cfg.conversion_wait}) begin
                  time_mark = p.now_ms;
                  phase = (phase == PH_BRIDGE_WAIT) ? PH_BRIDGE_STATUS : PH_TEMP_STATUS;
               end
            end
            PH_BRIDGE_STATUS, PH_TEMP_STATUS: begin
               // A failed status read is treated as busy.
               r.bus_op = BUS_READ1;
               if (p.bus_ok && (p.rx_status & STATUS_BUSY_MASK) == 8'h00) begin
                  phase = (phase == PH_BRIDGE_STATUS) ? PH_BRIDGE_READ : PH_TEMP_READ;
               end
            end
            PH_BRIDGE_READ: begin
               r.bus_op = BUS_READ4;
               if (p.bus_ok) begin
                  bridge_store = {p.rx_byte1, p.rx_byte2, p.rx_byte3};
                  r.bridge_new = 1'b1;
               end
               phase = PH_TEMP_WRITE;
            end
            PH_TEMP_WRITE: begin
               r.bus_op   = BUS_WRITE;
               r.tx_byte0 = cfg.temp_command;
               r.tx_byte1 = TEMP_ARG_BYTE;
               r.tx_byte2 = TEMP_ARG_BYTE;
               time_mark  = p.now_ms;
               phase      = PH_TEMP_WAIT;
            end
            PH_TEMP_READ: begin
               r.bus_op = BUS_READ4;
               if (p.bus_ok) begin
                  temp_store = {p.rx_byte1, p.rx_byte2};
                  r.temp_new = 1'b1;
               end
               time_mark = p.now_ms;
               phase     = PH_PAUSE;
            end
            PH_PAUSE: begin
               if (elapsed > {16'h0000, cfg.cycle_pause}) begin
                  time_mark = p.now_ms;
                  phase     = PH_BRIDGE_WRITE;
               end
            end
            default: phase = PH_BRIDGE_WRITE;
         endcase
         r.bridge_value = bridge_store;
         r.temp_value   = temp_store;
         expected_q.push_back(r);
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= 50) $display("MISMATCH at result %0d: %s", results, msg);
      endtask

      task check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_q.size() == 0) begin
            report_mismatch("result item with no poll waiting for it");
            return;
         end
         want = expected_q.pop_front();
         results++;
         bridge_captures += want.bridge_new;
         temp_captures   += want.temp_new;
         if (got.bus_op !== want.bus_op)
            report_mismatch($sformatf("bus_op %0d, expected %0d", got.bus_op, want.bus_op));
         if (got.tx_byte0 !== want.tx_byte0)
            report_mismatch($sformatf("tx_byte0 %h, expected %h", got.tx_byte0, want.tx_byte0));
         if (got.tx_byte1 !== want.tx_byte1)
            report_mismatch($sformatf("tx_byte1 %h, expected %h", got.tx_byte1, want.tx_byte1));
         if (got.tx_byte2 !== want.tx_byte2)
            report_mismatch($sformatf("tx_byte2 %h, expected %h", got.tx_byte2, want.tx_byte2));
         if (got.bridge_value !== want.bridge_value)
            report_mismatch($sformatf("bridge_value %h, expected %h",
                                      got.bridge_value, want.bridge_value));
         if (got.temp_value !== want.temp_value)
            report_mismatch($sformatf("temp_value %h, expected %h",
                                      got.temp_value, want.temp_value));
         if (got.bridge_new !== want.bridge_new)
            report_mismatch($sformatf("bridge_new %b, expected %b",
                                      got.bridge_new, want.bridge_new));
         if (got.temp_new !== want.temp_new)
            report_mismatch($sformatf("temp_new %b, expected %b", got.temp_new, want.temp_new));
      endtask
   endclass

   logic clock;
   logic reset;

   bsms_req_if req_chan ();
   bsms_rsp_if rsp_chan ();
   bsms_csr_if csr_chan ();

   bridge_sensor_measure_sequencer u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   measure_scoreboard_type sb = new();

   // Stimulus bookkeeping. sim_ms is the running system time that polls carry.
   logic [31:0] sim_ms;
   int unsigned rsp_stall_pct;
   int unsigned holds_asked;
   int unsigned holds_done;
   int unsigned hold_left;
   int unsigned cycle_count;
   int unsigned random_polls;
   int unsigned settings_used;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Every input is at a known value before the first edge.
   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      csr_chan.valid = 1'b0;
      csr_chan.data  = '0;
      rsp_chan.ready = 1'b0;
      sim_ms         = '0;
      rsp_stall_pct  = 0;
      holds_asked    = 0;
      holds_done     = 0;
      hold_left      = 0;
      cycle_count    = 0;
      random_polls   = 0;
      settings_used  = 1;
   end

   // Receiver. It stalls at random at the rate the current segment asks for, and
   // when the stimulus asks for a hold-off it keeps ready low for a long stretch
   // of its own counting, so that the output register fills and the block in turn
   // refuses further polls.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_done != holds_asked) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Result monitor: outputs are sampled at the edge, before the block's own
   // updates for that edge take effect.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) sb.check_result(rsp_chan.data);
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d results outstanding.",
                  cycle_count, sb.expected_q.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Offers one poll item and holds it until the block takes it. The scoreboard
   // is told in the same step, so the next item can be chosen from up-to-date state.
   task automatic send_poll(req_payload_type item);
      req_chan.data  <= item;
      req_chan.valid <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_poll(item);
   endtask

   // A poll whose time is given relative to the current time mark.
   task automatic directed_poll(logic [31:0] delta, logic ok, logic [7:0] status,
                                logic [7:0] b1, logic [7:0] b2, logic [7:0] b3);
      req_payload_type item;
      item.now_ms    = sb.time_mark + delta;
      item.bus_ok    = ok;
      item.rx_status = status;
      item.rx_byte1  = b1;
      item.rx_byte2  = b2;
      item.rx_byte3  = b3;
      sim_ms = item.now_ms;
      send_poll(item);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Random poll shaped by the phase the sequencer is in. In the waiting phases
   // the time lands on the exact threshold, one past it, or a spread around it,
   // so that waits both hold and expire; elsewhere time creeps forward. In every
   // phase it occasionally jumps instead, some jumps just short of the 32-bit wrap.
   function automatic req_payload_type random_poll();
      req_payload_type item;
      logic [31:0]     limit;
      logic            waiting;
      waiting = (sb.phase == PH_BRIDGE_WAIT || sb.phase == PH_TEMP_WAIT ||
                 sb.phase == PH_PAUSE);
      limit   = (sb.phase == PH_PAUSE) ? {16'h0000, sb.cfg.cycle_pause}
                                       : {16'h0000, sb.cfg.conversion_wait};
      if ($urandom_range(15) == 0) begin
         item.now_ms = $urandom_range(1) ? $urandom() : 32'hFFFF_FF00 + $urandom_range(255);
      end else if (waiting) begin
         case ($urandom_range(7))
            0:       item.now_ms = sb.time_mark + limit;
            1:       item.now_ms = sb.time_mark + limit + 1;
            default: item.now_ms = sb.time_mark + $urandom_range(limit + limit / 2 + 2);
         endcase
      end else begin
         item.now_ms = sim_ms + $urandom_range(3);
      end
      sim_ms         = item.now_ms;
      item.bus_ok    = ($urandom_range(99) >= 15);
      item.rx_status = pick_byte();
      if ($urandom_range(99) < 40) item.rx_status = item.rx_status | STATUS_BUSY_MASK;
      else item.rx_status = item.rx_status & ~STATUS_BUSY_MASK;
      item.rx_byte1 = pick_byte();
      item.rx_byte2 = pick_byte();
      item.rx_byte3 = pick_byte();
      return item;
   endfunction

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] wdata);
      csr_chan.data  <= '{index: index, wdata: wdata};
      csr_chan.valid <= 1'b1;
      do @(posedge clock); while (!csr_chan.ready);
      sb.write_register(index, wdata);
   endtask

   // Writes all six registers, plus the two unused indexes, which must be ignored.
   // The 8-bit registers get full 16-bit data so that the upper byte is dropped.
   task automatic configure(logic [15:0] bcmd, logic [15:0] bhigh, logic [15:0] blow,
                            logic [15:0] tcmd, logic [15:0] conv_wait, logic [15:0] pause_ms);
      logic [CSR_INDEX_W-1:0] spare_index;
      spare_index = REG_CYCLE_PAUSE + 3'd1;
      write_csr(REG_BRIDGE_COMMAND, bcmd);
      write_csr(REG_BRIDGE_ARG_HIGH, bhigh);
      write_csr(spare_index, 16'($urandom()));
      write_csr(REG_BRIDGE_ARG_LOW, blow);
      write_csr(REG_TEMP_COMMAND, tcmd);
      write_csr(spare_index + 3'd1, 16'($urandom()));
      write_csr(REG_CONVERSION_WAIT, conv_wait);
      write_csr(REG_CYCLE_PAUSE, pause_ms);
      csr_chan.valid <= 1'b0;
      settings_used++;
   endtask

   // Stops offering polls and waits until every expected result has come out,
   // then lets the block settle before anything else touches it.
   task automatic quiesce();
      req_chan.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_segment(int unsigned polls, int unsigned send_idle_pct,
                              int unsigned stall_pct, bit squeeze);
      rsp_stall_pct = stall_pct;
      for (int unsigned i = 0; i < polls; i++) begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
         if (squeeze && i == polls / 4) holds_asked++;
         send_poll(random_poll());
         random_polls++;
      end
   endtask

   initial begin
      int unsigned send_pct[4];
      int unsigned stall_pct[4];
      logic [15:0] conv_wait;
      logic [15:0] pause_ms;

      // Idling plans: none, sender idle, receiver stalling, both at a moderate rate.
      send_pct  = '{0, 70, 0, 27};
      stall_pct = '{0, 0, 70, 27};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed walk over full acquisition cycles with the reset register values
      // (10 ms conversion wait, 200 ms pause, zero command bytes). It starts just
      // short of the time wrap, sits on the bridge wait and pause thresholds first,
      // and covers a failed write, busy and failed status reads, a failed bridge
      // and temperature read, all-ones data and the ignored fourth temperature byte.
      directed_poll(32'hFFFF_FFF8, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
      directed_poll(32'd10,        1'b1, 8'h00, 8'h11, 8'h22, 8'h33);
      directed_poll(32'd11,        1'b1, 8'h00, 8'h11, 8'h22, 8'h33);
      directed_poll(32'd0,         1'b1, 8'h20, 8'h00, 8'h00, 8'h00);
      directed_poll(32'd1,         1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
      directed_poll(32'd2,         1'b1, 8'hDF, 8'h00, 8'h00, 8'h00);
      directed_poll(32'd3,         1'b1, 8'h00, 8'hFF, 8'hFF, 8'hFF);
      directed_poll(32'd1,         1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
      directed_poll(32'd0,         1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
      directed_poll(32'd11,        1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
      directed_poll(32'd1,         1'b1, 8'hFF, 8'h00, 8'h00, 8'h00);
      directed_poll(32'd2,         1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
      directed_poll(32'd3,         1'b0, 8'h00, 8'h12, 8'h34, 8'h56);
      directed_poll(32'd200,       1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
      directed_poll(32'd201,       1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
      directed_poll(32'd1,         1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
      directed_poll(32'hFFFF_FFFF, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
      directed_poll(32'd1,         1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
      directed_poll(32'd2,         1'b0, 8'h00, 8'hAA, 8'hAA, 8'hAA);
      directed_poll(32'd3,         1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
      directed_poll(32'd11,        1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
      directed_poll(32'd1,         1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
      directed_poll(32'd2,         1'b1, 8'h00, 8'hFF, 8'hFF, 8'hAA);
      directed_poll(32'd0,         1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
      directed_poll(32'd201,       1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
      quiesce();

      // Random segments. The first two use the register extremes; the rest draw
      // short waits mostly, with the odd full-range value. The idling plan rotates
      // so that every plan meets two settings, and the first segment carries
      // the long receiver hold-off.
      for (int unsigned s = 0; s < SEGMENTS; s++) begin
         case (s)
            0: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
            1: configure(16'hFF00, 16'hFF00, 16'hFF00, 16'hFF00, 16'hFFFF, 16'hFFFF);
            default: begin
               conv_wait = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(40));
               pause_ms  = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(400));
               configure(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                         conv_wait, pause_ms);
            end
         endcase
         run_segment(SEG_POLLS, send_pct[s % 4], stall_pct[s % 4], s == 0);
         quiesce();
      end

      $display("Ran 25 directed and %0d random polls over %0d register settings.",
               random_polls, settings_used);
      $display("Checked %0d results: %0d bridge and %0d temperature captures, %0d mismatches.",
               sb.results, sb.bridge_captures, sb.temp_captures, sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
